### design/amrr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the AMRR transmit rate adapter.
// No dependencies; used by every design file of the block.
package amrr_pkg;

    // Sizes of the node table and its fields
    localparam int NODE_COUNT = 16;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int MAX_RATES  = 16;
    localparam int RATE_BITS  = $clog2(MAX_RATES);
    localparam int COUNT_BITS = 16;
    localparam int SUCC_BITS  = 8;
    localparam int THR_BITS   = 8;
    localparam int RCNT_BITS  = 5;
    localparam int STG_BITS   = 3;

    // Rule constants
    localparam int ENOUGH_TRIES  = 10;
    localparam int SUCCESS_DIV   = 10;
    localparam int FAILURE_DIV   = 3;
    localparam int THRESH_GROWTH = 2;
    localparam int PROD_BITS     = COUNT_BITS + 4;

    // Item opcodes
    localparam logic [1:0] OP_COMPLETE = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_FLOOR  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_CEIL   = 2'd2;

    // Stream widths
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 16;

    // One node entry of the state memory
    typedef struct packed {
        logic [THR_BITS-1:0]   threshold;
        logic                  recovering;
        logic [SUCC_BITS-1:0]  success;
        logic [COUNT_BITS-1:0] second;
        logic [COUNT_BITS-1:0] first;
        logic [RATE_BITS-1:0]  rate;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        threshold:  THR_BITS'(1),
        recovering: 1'b0,
        success:    '0,
        second:     '0,
        first:      '0,
        rate:       '0
    };

    // One accepted input item
    typedef struct packed {
        logic [RATE_BITS-1:0] start;
        logic [STG_BITS-1:0]  stages;
        logic [NODE_BITS-1:0] node;
        logic [1:0]           opcode;
    } t_item;

    // Configuration registers as seen by the update logic
    typedef struct packed {
        logic [RCNT_BITS-1:0] rate_count;
        logic [THR_BITS-1:0]  thr_floor;
        logic [THR_BITS-1:0]  thr_ceil;
    } t_cfg;

endpackage

### design/amrr_update.sv
`timescale 1ns / 1ps
// Next-entry logic of the AMRR rate adapter: counting, tick rule, restart.
// Depends on amrr_pkg.
module amrr_next_entry (
    input  amrr_pkg::t_item  i_item,
    input  amrr_pkg::t_entry i_entry,
    input  amrr_pkg::t_cfg   i_cfg,
    output amrr_pkg::t_entry o_entry,
    output logic             o_changed
);

    logic [amrr_pkg::RATE_BITS-1:0]  top_rate;
    logic [amrr_pkg::PROD_BITS-1:0]  succ_bound;
    logic [amrr_pkg::PROD_BITS-1:0]  fail_bound;
    logic [amrr_pkg::PROD_BITS-1:0]  first_ext;
    logic                            enough;
    logic                            succ_hit;
    logic                            fail_hit;
    logic [amrr_pkg::SUCC_BITS-1:0]  succ_inc;
    logic [amrr_pkg::THR_BITS:0]     thr_dbl;
    logic [amrr_pkg::THR_BITS-1:0]   thr_grown;

    // Highest usable rate index from the rate count register
    always_comb begin
        if (i_cfg.rate_count == '0) begin
            top_rate = '0;
        end else if (i_cfg.rate_count >= amrr_pkg::RCNT_BITS'(amrr_pkg::MAX_RATES)) begin
            top_rate = amrr_pkg::RATE_BITS'(amrr_pkg::MAX_RATES - 1);
        end else begin
            top_rate = amrr_pkg::RATE_BITS'(i_cfg.rate_count - 1'b1);
        end
    end

    // Division-free forms of the success and failure tests:
    // second < first/10  <=>  10*(second+1) <= first
    // second > first/3   <=>  first < 3*second
    assign first_ext  = amrr_pkg::PROD_BITS'(i_entry.first);
    assign succ_bound = (amrr_pkg::PROD_BITS'(i_entry.second) + 1'b1)
                        * amrr_pkg::PROD_BITS'(amrr_pkg::SUCCESS_DIV);
    assign fail_bound = amrr_pkg::PROD_BITS'(i_entry.second)
                        * amrr_pkg::PROD_BITS'(amrr_pkg::FAILURE_DIV);
    assign enough   = i_entry.first > amrr_pkg::COUNT_BITS'(amrr_pkg::ENOUGH_TRIES);
    assign succ_hit = enough && (succ_bound <= first_ext);
    assign fail_hit = first_ext < fail_bound;

    // Saturating success count and capped threshold growth
    assign succ_inc  = (&i_entry.success) ? i_entry.success : i_entry.success + 1'b1;
    assign thr_dbl   = (amrr_pkg::THR_BITS+1)'(i_entry.threshold)
                       * (amrr_pkg::THR_BITS+1)'(amrr_pkg::THRESH_GROWTH);
    assign thr_grown = (thr_dbl < {1'b0, i_cfg.thr_ceil}) ?
                       amrr_pkg::THR_BITS'(thr_dbl) : i_cfg.thr_ceil;

    // Apply the item to the entry
    always_comb begin
        o_entry   = i_entry;
        o_changed = 1'b0;
        unique case (i_item.opcode)
            amrr_pkg::OP_COMPLETE: begin
                if (i_item.stages >= amrr_pkg::STG_BITS'(1) && !(&i_entry.first)) begin
                    o_entry.first = i_entry.first + 1'b1;
                end
                if (i_item.stages >= amrr_pkg::STG_BITS'(2) && !(&i_entry.second)) begin
                    o_entry.second = i_entry.second + 1'b1;
                end
            end
            amrr_pkg::OP_TICK: begin
                if (succ_hit) begin
                    o_entry.success = succ_inc;
                    if (succ_inc == i_entry.threshold && i_entry.rate < top_rate) begin
                        o_entry.recovering = 1'b1;
                        o_entry.rate       = i_entry.rate + 1'b1;
                    end else begin
                        o_entry.recovering = 1'b0;
                    end
                end else if (fail_hit) begin
                    o_entry.success    = '0;
                    o_entry.recovering = 1'b0;
                    if (i_entry.rate != '0) begin
                        o_entry.threshold = i_entry.recovering ? thr_grown : i_cfg.thr_floor;
                        o_entry.rate      = i_entry.rate - 1'b1;
                    end
                end
                // Clear counters after a full period or a rate move
                if (enough || o_entry.rate != i_entry.rate) begin
                    o_entry.first  = '0;
                    o_entry.second = '0;
                end
                if (o_entry.rate != i_entry.rate) begin
                    o_entry.success = '0;
                    o_changed       = 1'b1;
                end
            end
            amrr_pkg::OP_RESTART: begin
                o_entry.rate       = (i_item.start > top_rate) ? top_rate : i_item.start;
                o_entry.first      = '0;
                o_entry.second     = '0;
                o_entry.success    = '0;
                o_entry.recovering = 1'b0;
                o_entry.threshold  = i_cfg.thr_floor;
                o_changed          = 1'b1;
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule

### design/amrr_tx_rate_adapter.sv
`timescale 1ns / 1ps
// Top level of the AMRR transmit rate adapter: node state memory, control, ports.
// Depends on amrr_pkg and amrr_next_entry.

// Keeps AMRR rate-control state for each peer node in a single-port state
// memory and returns one result beat (node, current rate, rate-changed flag)
// for every input beat. Each item first reads the node's entry from the
// memory (registered read), then updates it and writes it back while
// loading the output register. The next item is accepted in the cycle after
// the write-back, so a new item is never taken before the last one is
// written back; a full output register holds the update cycle.
// Entries never written read as the reset values (per-node valid bits), so
// no clearing pass is needed after reset. Configuration writes are always
// taken and must only be issued while the block is idle.
module amrr_tx_rate_adapter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream; tdata from bit 0: node_index[3:0], stages_tried[6:4],
    // start_rate[10:7], zero fill
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [amrr_pkg::IN_DATA_BITS-1:0]      i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                             i_s_tuser,
    // Result stream; tdata from bit 0: node_out[3:0], tx_rate[7:4],
    // rate_changed[8], zero fill
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [amrr_pkg::OUT_DATA_BITS-1:0]     o_m_tdata,
    // Configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [amrr_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [7:0]                             i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                                r_state;
    logic                                n_state;
    amrr_pkg::t_item                     r_item;
    amrr_pkg::t_entry                    r_rd_data;
    logic                                r_rd_valid;
    logic [amrr_pkg::NODE_COUNT-1:0]     r_valid;
    amrr_pkg::t_entry                    r_mem [amrr_pkg::NODE_COUNT];
    amrr_pkg::t_cfg                      r_cfg;
    logic                                r_out_valid;
    logic [amrr_pkg::OUT_DATA_BITS-1:0]  r_out_data;

    amrr_pkg::t_item                     in_item;
    amrr_pkg::t_entry                    cur_entry;
    amrr_pkg::t_entry                    upd_entry;
    logic                                upd_changed;
    logic                                s_fire;
    logic                                commit;

    // Unpack the input beat
    assign in_item.opcode = i_s_tuser;
    assign in_item.node   = i_s_tdata[amrr_pkg::NODE_BITS-1:0];
    assign in_item.stages = i_s_tdata[amrr_pkg::NODE_BITS +: amrr_pkg::STG_BITS];
    assign in_item.start  = i_s_tdata[amrr_pkg::NODE_BITS + amrr_pkg::STG_BITS +:
                                      amrr_pkg::RATE_BITS];

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign commit      = (r_state == ST_EXEC) && (!r_out_valid || i_m_tready);
    assign o_cfg_ready = 1'b1;

    // Never-written entries read as reset values
    assign cur_entry = r_rd_valid ? r_rd_data : amrr_pkg::ENTRY_RESET;

    amrr_next_entry u_update (
        .i_item    (r_item),
        .i_entry   (cur_entry),
        .i_cfg     (r_cfg),
        .o_entry   (upd_entry),
        .o_changed (upd_changed)
    );

    // Sequence read then update
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_fire) n_state = ST_EXEC;
            ST_EXEC: if (commit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // State memory: read on accept, write back on commit
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_item    <= in_item;
            r_rd_data <= r_mem[in_item.node];
        end
        if (commit) begin
            r_mem[r_item.node] <= upd_entry;
        end
    end

    // Valid bits and the valid flag of the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_rd_valid <= r_valid[in_item.node];
            end
            if (commit) begin
                r_valid[r_item.node] <= 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_count <= amrr_pkg::RCNT_BITS'(12);
            r_cfg.thr_floor  <= amrr_pkg::THR_BITS'(1);
            r_cfg.thr_ceil   <= amrr_pkg::THR_BITS'(10);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                amrr_pkg::CFG_RATE_COUNT:
                    r_cfg.rate_count <= i_cfg_data[amrr_pkg::RCNT_BITS-1:0];
                amrr_pkg::CFG_THR_FLOOR:  r_cfg.thr_floor <= i_cfg_data;
                amrr_pkg::CFG_THR_CEIL:   r_cfg.thr_ceil  <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= amrr_pkg::OUT_DATA_BITS'({upd_changed, upd_entry.rate, r_item.node});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### design/amrr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the AMRR rate adapter, bound to the top level.
// Depends on amrr_pkg and amrr_tx_rate_adapter.
module amrr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic [amrr_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [amrr_pkg::OUT_DATA_BITS-1:0] o_m_tdata
);

    // A beat in flight blocks the input for the update cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted during update cycle");

    // With the output empty, the accepted beat is updated without a stall and its result beat appears
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> ##1 o_m_tvalid)
        else $error("result beat missing");

    // The result echoes the accepted node
    a_node_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !o_m_tvalid) |=> ##1
        (o_m_tdata[amrr_pkg::NODE_BITS-1:0] ==
         $past(i_s_tdata[amrr_pkg::NODE_BITS-1:0], 2)))
        else $error("result node differs from accepted node");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind amrr_tx_rate_adapter amrr_checker u_amrr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
